// File: hw/rtl/cab_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the constant-alpha pixel blend.
// Used by cab_src_scale, cab_dst_blend and the top level; depends on nothing.
package cab_pkg;

	localparam int unsigned ChanW = 8;
	localparam int unsigned ProdW = 2 * ChanW;

	// Source format codes. The undefined code is read as a 24-bit source.
	localparam logic [1:0] FMT_RGB565 = 2'd0;
	localparam logic [1:0] FMT_RGB24  = 2'd1;
	localparam logic [1:0] FMT_RGBA32 = 2'd2;
	localparam logic [1:0] FMT_UNDEF  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_CONST_ALPHA = 2'd0;
	localparam logic [1:0] REG_PIXEL_ALPHA = 2'd1;
	localparam logic [1:0] REG_SRC_FORMAT  = 2'd2;

	localparam logic [ChanW-1:0] CHAN_MAX = 8'hFF;

	typedef struct packed {
		logic [ChanW-1:0] const_alpha;
		logic             use_pixel_alpha;
		logic [1:0]       source_format;
	} cfg_t;

	// Stage advance enables, one per pipeline register.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_en_t;

	// Item after the source has been scaled and the blend alpha chosen.
	typedef struct packed {
		logic [ChanW-1:0] src_r;
		logic [ChanW-1:0] src_g;
		logic [ChanW-1:0] src_b;
		logic [ChanW-1:0] src_a;
		logic [ChanW-1:0] inv_alpha;
		logic [ChanW-1:0] dst_r;
		logic [ChanW-1:0] dst_g;
		logic [ChanW-1:0] dst_b;
		logic             err;
	} mid_t;

	// Exact floor(x / 255) for any product of two bytes.
	function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
		logic [ProdW-1:0] t;
		t = x + {{ChanW{1'b0}}, x[ProdW-1:ChanW]} + {{(ProdW-1){1'b0}}, 1'b1};
		return t[ProdW-1:ChanW];
	endfunction

endpackage

// File: hw/rtl/cab_src_scale.sv
`timescale 1ns / 1ps
// Stages one and two: widen the source, scale it by the constant alpha and
// pick the blend alpha. Depends on cab_pkg.
module cab_src_scale (
	input  logic                           clk,
	input  cab_pkg::pipe_en_t              pen,
	input  cab_pkg::cfg_t                  cfg,
	input  logic [31:0]                    source_pixel,
	input  logic [23:0]                    dest_color,
	output cab_pkg::mid_t                  mid_s2
);

	logic [cab_pkg::ChanW-1:0] er, eg, eb;
	logic                      is32, err;

	logic [cab_pkg::ProdW-1:0] pr_s1, pg_s1, pb_s1, pa_s1;
	logic [cab_pkg::ChanW-1:0] ca_s1;
	logic                      is32_s1, upa_s1, err_s1;
	logic [23:0]               dest_s1;

	logic [cab_pkg::ChanW-1:0] sa, alpha;
	logic [cab_pkg::ProdW-1:0] ca_w;

	always_comb begin
		is32 = (cfg.source_format == cab_pkg::FMT_RGBA32);
		err  = cfg.use_pixel_alpha && !is32;
		ca_w = {{cab_pkg::ChanW{1'b0}}, cfg.const_alpha};
		if (cfg.source_format == cab_pkg::FMT_RGB565) begin
			er = {source_pixel[4:0], source_pixel[4:2]};
			eg = {source_pixel[10:5], source_pixel[10:9]};
			eb = {source_pixel[15:11], source_pixel[15:13]};
		end else begin
			er = source_pixel[7:0];
			eg = source_pixel[15:8];
			eb = source_pixel[23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (pen.en_s1) begin
			pr_s1   <= {{cab_pkg::ChanW{1'b0}}, er} * ca_w;
			pg_s1   <= {{cab_pkg::ChanW{1'b0}}, eg} * ca_w;
			pb_s1   <= {{cab_pkg::ChanW{1'b0}}, eb} * ca_w;
			pa_s1   <= {{cab_pkg::ChanW{1'b0}}, source_pixel[31:24]} * ca_w;
			ca_s1   <= cfg.const_alpha;
			is32_s1 <= is32;
			upa_s1  <= cfg.use_pixel_alpha;
			err_s1  <= err;
			dest_s1 <= dest_color;
		end
	end

	always_comb begin
		sa    = is32_s1 ? cab_pkg::div255(pa_s1) : ca_s1;
		alpha = upa_s1 ? sa : ca_s1;
	end

	always_ff @(posedge clk) begin
		if (pen.en_s2) begin
			mid_s2.src_r     <= cab_pkg::div255(pr_s1);
			mid_s2.src_g     <= cab_pkg::div255(pg_s1);
			mid_s2.src_b     <= cab_pkg::div255(pb_s1);
			mid_s2.src_a     <= sa;
			mid_s2.inv_alpha <= cab_pkg::CHAN_MAX - alpha;
			mid_s2.dst_r     <= dest_s1[7:0];
			mid_s2.dst_g     <= dest_s1[15:8];
			mid_s2.dst_b     <= dest_s1[23:16];
			mid_s2.err       <= err_s1;
		end
	end

endmodule

// File: hw/rtl/cab_dst_blend.sv
`timescale 1ns / 1ps
// Stages three and four: scale the destination by the inverse alpha, add the
// scaled source and saturate. Depends on cab_pkg.
module cab_dst_blend (
	input  logic                      clk,
	input  cab_pkg::pipe_en_t         pen,
	input  cab_pkg::mid_t             mid_s2,
	output logic [cab_pkg::ChanW-1:0] red_s4,
	output logic [cab_pkg::ChanW-1:0] green_s4,
	output logic [cab_pkg::ChanW-1:0] blue_s4,
	output logic [cab_pkg::ChanW-1:0] alpha_s4,
	output logic                      err_s4
);

	logic [cab_pkg::ProdW-1:0] pr_s3, pg_s3, pb_s3;
	cab_pkg::mid_t             mid_s3;
	logic [cab_pkg::ProdW-1:0] inv_w;

	assign inv_w = {{cab_pkg::ChanW{1'b0}}, mid_s2.inv_alpha};

	always_ff @(posedge clk) begin
		if (pen.en_s3) begin
			pr_s3  <= {{cab_pkg::ChanW{1'b0}}, mid_s2.dst_r} * inv_w;
			pg_s3  <= {{cab_pkg::ChanW{1'b0}}, mid_s2.dst_g} * inv_w;
			pb_s3  <= {{cab_pkg::ChanW{1'b0}}, mid_s2.dst_b} * inv_w;
			mid_s3 <= mid_s2;
		end
	end

	function automatic logic [cab_pkg::ChanW-1:0] blend_chan(
		input logic [cab_pkg::ProdW-1:0] prod,
		input logic [cab_pkg::ChanW-1:0] src
	);
		logic [cab_pkg::ChanW:0] sum;
		sum = {1'b0, cab_pkg::div255(prod)} + {1'b0, src};
		return sum[cab_pkg::ChanW] ? cab_pkg::CHAN_MAX : sum[cab_pkg::ChanW-1:0];
	endfunction

	// A rejected setting passes the destination through with zero alpha.
	always_ff @(posedge clk) begin
		if (pen.en_s4) begin
			err_s4 <= mid_s3.err;
			if (mid_s3.err) begin
				red_s4   <= mid_s3.dst_r;
				green_s4 <= mid_s3.dst_g;
				blue_s4  <= mid_s3.dst_b;
				alpha_s4 <= '0;
			end else begin
				red_s4   <= blend_chan(pr_s3, mid_s3.src_r);
				green_s4 <= blend_chan(pg_s3, mid_s3.src_g);
				blue_s4  <= blend_chan(pb_s3, mid_s3.src_b);
				alpha_s4 <= mid_s3.src_a;
			end
		end
	end

endmodule

// File: hw/rtl/constant_alpha_pixel_blend_top.sv
`timescale 1ns / 1ps
// Constant-alpha source-over pixel blend, four register stages.
// An accepted item passes the s1, s2, s3 and s4 registers in turn, and
// its result is on m_tdata while the s4 output register holds it.
// Throughput: one item per cycle; every stage is fully pipelined, and the
// input stalls only once all four stages hold items the receiver refuses.
// Reset clears all valid bits and loads the registers with alpha 255,
// per-pixel alpha off and the 32-bit source format. Depends on cab_pkg.
module constant_alpha_pixel_blend_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // source_pixel [31:0], dest_color [55:32]
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic [0:0]  m_tuser    // setting_error
);

	cab_pkg::cfg_t     cfg_q;
	cab_pkg::pipe_en_t pen;
	cab_pkg::mid_t     mid_s2;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [7:0] red_s4, green_s4, blue_s4, alpha_s4;
	logic       err_s4;

	// Configuration registers. Index three is outside the list and ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.const_alpha     <= cab_pkg::CHAN_MAX;
			cfg_q.use_pixel_alpha <= 1'b0;
			cfg_q.source_format   <= cab_pkg::FMT_RGBA32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cab_pkg::REG_CONST_ALPHA: cfg_q.const_alpha     <= cfg_data;
				cab_pkg::REG_PIXEL_ALPHA: cfg_q.use_pixel_alpha <= cfg_data[0];
				cab_pkg::REG_SRC_FORMAT:  cfg_q.source_format   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or when its content moves on. The last
	// stage is the output register, so an item is taken while a result waits
	// as long as some stage ahead of it has room.
	always_comb begin
		pen.en_s4 = !v_s4 || m_tready;
		pen.en_s3 = !v_s3 || pen.en_s4;
		pen.en_s2 = !v_s2 || pen.en_s3;
		pen.en_s1 = !v_s1 || pen.en_s2;
	end

	assign s_tready = pen.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (pen.en_s1) v_s1 <= s_tvalid;
			if (pen.en_s2) v_s2 <= v_s1;
			if (pen.en_s3) v_s3 <= v_s2;
			if (pen.en_s4) v_s4 <= v_s3;
		end
	end

	cab_src_scale u_src (
		.clk          (clk),
		.pen          (pen),
		.cfg          (cfg_q),
		.source_pixel (s_tdata[31:0]),
		.dest_color   (s_tdata[55:32]),
		.mid_s2       (mid_s2)
	);

	cab_dst_blend u_dst (
		.clk      (clk),
		.pen      (pen),
		.mid_s2   (mid_s2),
		.red_s4   (red_s4),
		.green_s4 (green_s4),
		.blue_s4  (blue_s4),
		.alpha_s4 (alpha_s4),
		.err_s4   (err_s4)
	);

	assign m_tvalid   = v_s4;
	assign m_tdata    = {alpha_s4, blue_s4, green_s4, red_s4};
	assign m_tuser[0] = err_s4;

endmodule
